// ===== design/sli_pkg.sv =====
// shared types, codes and defaults for the sorted list block
package sli_pkg;

  // default number of stored values
  localparam int CAPACITY_DEF = 16;

  // operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_DUMP   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // input item
  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load_in;
    logic       do_insert;
    logic       do_remove;
    logic       rotate;
    logic       clr_idx;
    logic       load_out;
    logic [1:0] out_status;
    logic       out_sel_data;
    logic       out_last;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       found;
    logic       empty;
    logic       dump_last;
  } sts_t;

endpackage

// ===== design/sli_ctrl.sv =====
// controller state machine for the sorted list block
module sli_ctrl
  import sli_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DUMP = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // output register can take a new item
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.func)
          FUNC_INSERT: begin
            if (slot_free) begin
              cmd.load_out   = 1'b1;
              cmd.out_last   = 1'b1;
              cmd.out_status = sts.full ? ST_FULL : ST_OK;
              cmd.do_insert  = !sts.full;
              state_nxt      = S_IDLE;
            end
          end
          FUNC_REMOVE: begin
            if (slot_free) begin
              cmd.load_out   = 1'b1;
              cmd.out_last   = 1'b1;
              cmd.out_status = sts.found ? ST_OK : ST_NOTFOUND;
              cmd.do_remove  = sts.found;
              state_nxt      = S_IDLE;
            end
          end
          FUNC_DUMP: begin
            if (sts.empty) begin
              if (slot_free) begin
                cmd.load_out   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = ST_EMPTY;
                state_nxt      = S_IDLE;
              end
            end else begin
              cmd.clr_idx = 1'b1;
              state_nxt   = S_DUMP;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_DUMP: begin
        if (slot_free) begin
          cmd.load_out     = 1'b1;
          cmd.out_status   = ST_OK;
          cmd.out_sel_data = 1'b1;
          cmd.out_last     = sts.dump_last;
          cmd.rotate       = 1'b1;
          if (sts.dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/sli_dpath.sv =====
// datapath: row of value cells with parallel compares, count and result register
module sli_dpath
  import sli_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_item_t out_item
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] cell_r   [CAPACITY];
  logic signed [31:0] cell_nxt [CAPACITY];
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  in_item_t           item_r;
  out_item_t          out_r;
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] pre;

  // per-cell compares against the held value
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i]    = (CW'(i) < count_r) && (cell_r[i] < item_r.value);
      match[i] = (CW'(i) < count_r) && (cell_r[i] == item_r.value);
    end
  end

  // first match and everything after it, per cell from a constant mask
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      pre[i] = |(match & ((CAPACITY'(2) << i) - CAPACITY'(1)));
    end
  end

  // next cell values: insert shifts up, remove shifts down, dump rotates
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
      if (cmd.do_insert) begin
        if (!lt[i]) begin
          if (i == 0) begin
            cell_nxt[i] = item_r.value;
          end else if (lt[(i + CAPACITY - 1) % CAPACITY]) begin
            cell_nxt[i] = item_r.value;
          end else begin
            cell_nxt[i] = cell_r[(i + CAPACITY - 1) % CAPACITY];
          end
        end
      end else if (cmd.do_remove) begin
        if (pre[i] && (i < CAPACITY - 1)) begin
          cell_nxt[i] = cell_r[(i + 1) % CAPACITY];
        end
      end else if (cmd.rotate) begin
        if (CW'(i) == count_r - CW'(1)) begin
          cell_nxt[i] = cell_r[0];
        end else if (i < CAPACITY - 1) begin
          cell_nxt[i] = cell_r[(i + 1) % CAPACITY];
        end
      end
    end
  end

  // count and dump position
  always_comb begin
    count_nxt = count_r;
    if (cmd.do_insert) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.do_remove) begin
      count_nxt = count_r - CW'(1);
    end
    idx_nxt = idx_r;
    if (cmd.clr_idx) begin
      idx_nxt = '0;
    end else if (cmd.rotate) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // cells, held item and result register carry no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
    if (cmd.load_in) begin
      item_r <= in_item;
    end
    if (cmd.load_out) begin
      out_r.status <= cmd.out_status;
      out_r.data   <= cmd.out_sel_data ? cell_r[0] : 32'sd0;
      out_r.last   <= cmd.out_last;
    end
  end

  // status to the controller
  assign sts.func      = item_r.func;
  assign sts.full      = (count_r == CW'(CAPACITY));
  assign sts.found     = |match;
  assign sts.empty     = (count_r == '0);
  assign sts.dump_last = (idx_r == count_r - CW'(1));
  assign out_item      = out_r;

endmodule

// ===== design/sorted_list_insert_remove_top.sv =====
// top level of the sorted list block: insert, remove and ascending dump
//
// Keeps up to CAPACITY signed 32-bit values in ascending order.
// Input channel: in_valid, in_stall, in_item (func, value). An item is taken
// when in_valid is high and in_stall low. func selects insert, remove of the
// first equal value, or dump; the unused code is dropped without a result.
// Result channel: out_valid, out_stall, out_item (status, data, last).
// Insert and remove give one result: the item is captured, then compared
// and shifted over the cells, and the result is written to the output
// register; no new item is taken until that result is written.
// A dump gives count results, one per cycle unless out_stall holds them,
// after a setup step; the cell row rotates once per result.
// A dump of an empty list gives one result with status empty.
// Results sit in an output register; the next item is taken while the
// last result still waits. When out_stall is high the result holds and
// the block waits before writing another.
// Reset (rst_n low, synchronous) empties the list and drops any result.
module sorted_list_insert_remove_top
  import sli_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  cmd_t cmd;
  sts_t sts;

  // controller
  sli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  sli_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

  // busy straight after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while previous one in progress");

  // no insert into a full list
  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_insert |-> !sts.full)
    else $error("insert into full list");

  // a remove only shifts when a match exists
  a_remove_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_remove |-> sts.found && !sts.empty)
    else $error("remove without match");

  // each dump step writes a result
  a_rotate_emits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rotate |=> out_valid && (out_item.status == ST_OK))
    else $error("dump step without result");

endmodule
